FILE: rtl/core/event_history_ring_assert.svh
// Assertion macros for the event history ring.
`ifndef EVENT_HISTORY_RING_ASSERT_SVH
`define EVENT_HISTORY_RING_ASSERT_SVH
`ifndef SYNTHESIS
`define EHR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("event history ring check failed");
`define EHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("event history ring check failed");
`else
`define EHR_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define EHR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/ehr_pkg.sv
// Shared types and constants for the event history ring.
`default_nettype none
package ehr_pkg;

    localparam int CAPACITY = 64;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 7;
    localparam int SEQ_W    = 16;
    localparam int ID_W     = 32;
    localparam int TIME_W   = 32;
    localparam int LVL_W    = 8;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_cmd               cmd;
        logic [SEQ_W-1:0]   seq_in;
        logic [ID_W-1:0]    id_in;
        logic [TIME_W-1:0]  time_in;
        logic [LVL_W-1:0]   levels_in;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [ID_W-1:0]    id_out;
        logic [TIME_W-1:0]  time_out;
        logic [LVL_W-1:0]   levels_out;
        logic [SEQ_W-1:0]   oldest_after;
        logic [CNT_W-1:0]   fill_count;
        logic [SEQ_W-1:0]   newest_seq;
    } t_out_item;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  tm;
        logic [LVL_W-1:0]   lvl;
    } t_entry;

    typedef struct packed {
        logic               we;
        logic [PTR_W-1:0]   waddr;
        t_entry             wentry;
        logic [PTR_W-1:0]   raddr;
    } t_mem_req;

endpackage
`default_nettype wire

FILE: rtl/core/event_history_ring.sv
// Top level of the event history ring: sequencer, entry memory and output register.
//
//  Channel   Direction  Valid          Stall          Beat
//  input     in         i_in_valid     o_in_stall     i_in  (ehr_pkg::t_in_item)
//  output    out        o_out_valid    i_out_stall    o_out (ehr_pkg::t_out_item)
//
// An insert writes its entry on acceptance and moves through the emit state into the output
// register; a lookup, reading one entry a cycle, scans the filled entries newest first and
// moves through the last and emit states into the register (straight to emit when empty).
// Reset clears the write pointer, the fill count and the newest sequence; the entry
// memory is not cleared, and only entries already written are used by a lookup.
// A stalled output holds its beat, and the next item is taken meanwhile.
`default_nettype none
`include "event_history_ring_assert.svh"
module event_history_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ehr_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ehr_pkg::t_out_item o_out
);

    ehr_pkg::t_mem_req  mem_req;
    ehr_pkg::t_entry    mem_rd;
    ehr_pkg::t_out_item res;
    logic               res_valid;
    logic               res_ready;
    logic               r_out_valid;
    ehr_pkg::t_out_item r_out;

    ehr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_mem       (mem_req),
        .i_rd        (mem_rd),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    ehr_mem u_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rd  (mem_rd)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `EHR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `EHR_ASSERT_NEXT(a_res_lands, i_clk, i_rst_n, res_valid && res_ready, o_out_valid)
    `EHR_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, o_out_valid, o_out.fill_count <= ehr_pkg::CNT_W'(ehr_pkg::CAPACITY))
    `EHR_ASSERT_NOW(a_found_filled, i_clk, i_rst_n, o_out_valid && o_out.found, o_out.fill_count != '0)

endmodule
`default_nettype wire

FILE: rtl/core/ehr_mem.sv
// Event entry memory with one write port and one registered read port.
`default_nettype none
module ehr_mem (
    input  logic              i_clk,
    input  ehr_pkg::t_mem_req i_req,
    output ehr_pkg::t_entry   o_rd
);

    ehr_pkg::t_entry r_mem [ehr_pkg::CAPACITY];
    ehr_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wentry;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rd = r_rd;

endmodule
`default_nettype wire

FILE: rtl/core/ehr_ctrl.sv
// Sequencer and compare unit that insert and scan the ring.
`default_nettype none
module ehr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ehr_pkg::t_in_item  i_in,
    output ehr_pkg::t_mem_req  o_mem,
    input  ehr_pkg::t_entry    i_rd,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output ehr_pkg::t_out_item o_res
);

    ehr_pkg::t_state               r_state,  n_state;
    logic [ehr_pkg::PTR_W-1:0]     r_wptr,   n_wptr;
    logic [ehr_pkg::CNT_W-1:0]     r_count,  n_count;
    logic [ehr_pkg::SEQ_W-1:0]     r_newest, n_newest;
    logic                          r_issued, n_issued;
    logic [ehr_pkg::PTR_W-1:0]     r_addr,   n_addr;
    logic [ehr_pkg::CNT_W-1:0]     r_k,      n_k;
    logic [ehr_pkg::SEQ_W-1:0]     r_req,    n_req;
    logic                          r_found,  n_found;
    logic [ehr_pkg::ID_W-1:0]      r_id,     n_id;
    logic [ehr_pkg::TIME_W-1:0]    r_tm,     n_tm;
    logic [ehr_pkg::LVL_W-1:0]     r_lv,     n_lv;
    logic [ehr_pkg::SEQ_W-1:0]     r_best,   n_best;
    logic [ehr_pkg::SEQ_W-1:0]     r_bdist,  n_bdist;
    logic [ehr_pkg::SEQ_W-1:0]     scan_gap;
    logic [ehr_pkg::PTR_W-1:0]     wptr_prev;
    logic [ehr_pkg::PTR_W-1:0]     addr_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ehr_pkg::ST_IDLE;
            r_wptr   <= '0;
            r_count  <= '0;
            r_newest <= '0;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wptr   <= n_wptr;
            r_count  <= n_count;
            r_newest <= n_newest;
            r_issued <= n_issued;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_k     <= n_k;
        r_req   <= n_req;
        r_found <= n_found;
        r_id    <= n_id;
        r_tm    <= n_tm;
        r_lv    <= n_lv;
        r_best  <= n_best;
        r_bdist <= n_bdist;
    end

    assign wptr_prev = (r_wptr == '0) ? ehr_pkg::PTR_W'(ehr_pkg::CAPACITY - 1)
                                      : r_wptr - 1'b1;
    assign addr_prev = (r_addr == '0) ? ehr_pkg::PTR_W'(ehr_pkg::CAPACITY - 1)
                                      : r_addr - 1'b1;
    assign scan_gap  = i_rd.seq - r_req;

    always_comb begin
        n_state  = r_state;
        n_wptr   = r_wptr;
        n_count  = r_count;
        n_newest = r_newest;
        n_issued = (r_state == ehr_pkg::ST_SCAN);
        n_addr   = r_addr;
        n_k      = r_k;
        n_req    = r_req;
        n_found  = r_found;
        n_id     = r_id;
        n_tm     = r_tm;
        n_lv     = r_lv;
        n_best   = r_best;
        n_bdist  = r_bdist;

        o_mem.we            = 1'b0;
        o_mem.waddr         = r_wptr;
        o_mem.wentry.seq    = i_in.seq_in;
        o_mem.wentry.id     = i_in.id_in;
        o_mem.wentry.tm     = i_in.time_in;
        o_mem.wentry.lvl    = i_in.levels_in;
        o_mem.raddr         = r_addr;

        unique case (r_state)
            ehr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_found = 1'b0;
                    n_id    = '0;
                    n_tm    = '0;
                    n_lv    = '0;
                    if (i_in.cmd == ehr_pkg::CMD_INSERT) begin
                        o_mem.we = 1'b1;
                        n_wptr   = (r_wptr == ehr_pkg::PTR_W'(ehr_pkg::CAPACITY - 1))
                                   ? '0 : r_wptr + 1'b1;
                        n_count  = (r_count == ehr_pkg::CNT_W'(ehr_pkg::CAPACITY))
                                   ? r_count : r_count + 1'b1;
                        n_newest = i_in.seq_in;
                        n_best   = '0;
                        n_state  = ehr_pkg::ST_EMIT;
                    end else begin
                        n_req   = i_in.seq_in;
                        n_best  = r_newest;
                        n_bdist = '1;
                        n_addr  = wptr_prev;
                        n_k     = '0;
                        n_state = (r_count == '0) ? ehr_pkg::ST_EMIT : ehr_pkg::ST_SCAN;
                    end
                end
            end
            ehr_pkg::ST_SCAN: begin
                n_addr = addr_prev;
                n_k    = r_k + 1'b1;
                if (r_k == r_count - 1'b1) begin
                    n_state = ehr_pkg::ST_LAST;
                end
            end
            ehr_pkg::ST_LAST: begin
                n_state = ehr_pkg::ST_EMIT;
            end
            ehr_pkg::ST_EMIT: begin
                if (i_res_ready) begin
                    n_state = ehr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ehr_pkg::ST_IDLE;
            end
        endcase

        // The scan runs newest first, so the first match seen is the newest one.
        if (r_issued) begin
            if (i_rd.seq == r_req && !r_found) begin
                n_found = 1'b1;
                n_id    = i_rd.id;
                n_tm    = i_rd.tm;
                n_lv    = i_rd.lvl;
            end
            if (i_rd.seq != r_req && scan_gap < r_bdist) begin
                n_bdist = scan_gap;
                n_best  = i_rd.seq;
            end
        end
    end

    assign o_in_stall         = (r_state != ehr_pkg::ST_IDLE);
    assign o_res_valid        = (r_state == ehr_pkg::ST_EMIT);
    assign o_res.found        = r_found;
    assign o_res.id_out       = r_id;
    assign o_res.time_out     = r_tm;
    assign o_res.levels_out   = r_lv;
    assign o_res.oldest_after = r_best;
    assign o_res.fill_count   = r_count;
    assign o_res.newest_seq   = r_newest;

endmodule
`default_nettype wire
